FILE: sv/stb_pkg.sv
// Shared types and constants for the soft timer bank.
`timescale 1ns / 1ps

package stb_pkg;

  localparam int CMD_W          = 3;
  localparam int SLOT_W         = 4;
  localparam int VALUE_W        = 32;
  localparam int STATUS_W       = 2;
  localparam int NUM_SLOTS      = 16;
  localparam int MAX_TIMERS_DEF = 16;
  // power of two keeps the pointer wrap natural
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CREATE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PAUSE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RESUME = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RESET  = 3'd5;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_EXISTS   = 2'd2,
    ST_NO_TIMER = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    K_TICK,
    K_CREATE,
    K_REMOVE,
    K_PAUSE,
    K_RESUME,
    K_RESET,
    K_NOP
  } kind_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_CMD,
    E_SWEEP,
    E_FLUSH
  } eng_state_t;

  typedef struct packed {
    kind_t               kind;
    logic [SLOT_W-1:0]   slot;
    logic                in_cap;
    logic [VALUE_W-1:0]  reload_value;
    logic                auto_reload;
    logic                run_enable;
  } item_t;

endpackage

FILE: sv/stb_in_if.sv
// Command channel of the soft timer bank.
`timescale 1ns / 1ps

interface stb_in_if;
  logic                        valid;
  logic                        ready;
  logic [stb_pkg::CMD_W-1:0]   cmd;
  logic [stb_pkg::SLOT_W-1:0]  slot;
  logic [stb_pkg::VALUE_W-1:0] reload_value;
  logic                        auto_reload;
  logic                        run_enable;

  modport source (output valid, cmd, slot, reload_value, auto_reload, run_enable,
                  input ready);
  modport sink (input valid, cmd, slot, reload_value, auto_reload, run_enable,
                output ready);
endinterface

FILE: sv/stb_out_if.sv
// Result channel of the soft timer bank.
`timescale 1ns / 1ps

interface stb_out_if;
  logic                         valid;
  logic                         ready;
  logic [stb_pkg::STATUS_W-1:0] status;
  logic                         fired;
  logic [stb_pkg::SLOT_W-1:0]   fired_slot;
  logic [stb_pkg::VALUE_W-1:0]  tick_count;
  logic                         last;

  modport source (output valid, status, fired, fired_slot, tick_count, last,
                  input ready);
  modport sink (input valid, status, fired, fired_slot, tick_count, last,
                output ready);
endinterface

FILE: sv/multi_channel_soft_timer_bank.sv
// Top level of the soft timer bank: command decode/queue and timer engine.
//
//   channel   dir   handshake      payload
//   items     in    valid/ready    cmd, slot, reload_value, auto_reload, run_enable
//   results   out   valid/ready    status, fired, fired_slot, tick_count, last
//
// A command other than tick is a read of the slot's count/reload memory,
// then the update and its result.
// A tick is a start, a sweep and a flush; the sweep reads MAX_TIMERS (at most
// 16) slots, one per cycle unless stalled, via the memory's single read port.
// Reset clears all flags, counters and the queue; the memory is not cleared,
// since an entry's value is used only after a create has written it.
// A stalled result register holds the sweep only when a second expiry is due.
`timescale 1ns / 1ps

module multi_channel_soft_timer_bank #(
  parameter int MAX_TIMERS = stb_pkg::MAX_TIMERS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  stb_in_if.sink    items,
  stb_out_if.source results
);

  logic           q_valid;
  logic           q_ready;
  stb_pkg::item_t q_item;

  stb_front #(
    .MAX_TIMERS (MAX_TIMERS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  stb_engine #(
    .MAX_TIMERS (MAX_TIMERS)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .results (results)
  );

endmodule

FILE: sv/stb_front.sv
// Command decode and the short queue in front of the timer engine.
`timescale 1ns / 1ps

module stb_front #(
  parameter int MAX_TIMERS = stb_pkg::MAX_TIMERS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  stb_in_if.sink         items,
  output logic           q_valid,
  input  logic           q_ready,
  output stb_pkg::item_t q_item
);

  localparam int QPTR_W = (stb_pkg::QUEUE_DEPTH > 1) ? $clog2(stb_pkg::QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(stb_pkg::QUEUE_DEPTH + 1);

  stb_pkg::item_t     entries [0:stb_pkg::QUEUE_DEPTH-1];
  stb_pkg::item_t     cls;
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  q_count;
  logic               push;
  logic               pop;

  always_comb begin
    cls.slot         = items.slot;
    cls.in_cap       = int'(items.slot) < MAX_TIMERS;
    cls.reload_value = items.reload_value;
    cls.auto_reload  = items.auto_reload;
    cls.run_enable   = items.run_enable;
    unique case (items.cmd)
      stb_pkg::CMD_TICK:   cls.kind = stb_pkg::K_TICK;
      stb_pkg::CMD_CREATE: cls.kind = stb_pkg::K_CREATE;
      stb_pkg::CMD_REMOVE: cls.kind = stb_pkg::K_REMOVE;
      stb_pkg::CMD_PAUSE:  cls.kind = stb_pkg::K_PAUSE;
      stb_pkg::CMD_RESUME: cls.kind = stb_pkg::K_RESUME;
      stb_pkg::CMD_RESET:  cls.kind = stb_pkg::K_RESET;
      default:             cls.kind = stb_pkg::K_NOP;
    endcase
  end

  assign items.ready = q_count != QCNT_W'(stb_pkg::QUEUE_DEPTH);
  assign push        = items.valid && items.ready;
  assign q_valid     = q_count != '0;
  assign pop         = q_valid && q_ready;
  assign q_item      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      priority if (push && !pop) q_count <= q_count + QCNT_W'(1);
      else if (pop && !push) q_count <= q_count - QCNT_W'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(stb_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

FILE: sv/stb_engine.sv
// Timer engine: slot flags, count/reload memory, tick sweep and result register.
`timescale 1ns / 1ps

module stb_engine #(
  parameter int MAX_TIMERS = stb_pkg::MAX_TIMERS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  stb_pkg::item_t q_item,
  stb_out_if.source      results
);

  localparam int DEPTH = (MAX_TIMERS < stb_pkg::NUM_SLOTS) ? MAX_TIMERS
                                                           : stb_pkg::NUM_SLOTS;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TIU_W = $clog2(DEPTH + 1);
  localparam int VW    = stb_pkg::VALUE_W;
  localparam int SW    = stb_pkg::SLOT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  stb_pkg::eng_state_t state, state_next;

  logic [DEPTH-1:0] slot_valid, valid_next;
  logic [DEPTH-1:0] slot_running, run_next;
  logic [DEPTH-1:0] slot_ar, ar_next;
  logic [TIU_W-1:0] timers_in_use, tiu_next;
  logic [VW-1:0]    tick_counter, tick_next;
  logic [IDX_W-1:0] proc_idx, proc_next;
  logic             pend_valid, pend_next;
  logic [SW-1:0]    pend_slot, pend_slot_next;

  logic [VW-1:0]    cnt_mem [0:DEPTH-1];
  logic [VW-1:0]    rel_mem [0:DEPTH-1];
  logic [VW-1:0]    cnt_q;
  logic [VW-1:0]    rel_q;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             cnt_we;
  logic [VW-1:0]    cnt_wdata;
  logic             rel_we;

  logic             out_valid;
  logic             out_free;
  logic             emit;
  stb_pkg::status_t emit_status;
  logic             emit_fired;
  logic [SW-1:0]    emit_slot;
  logic             emit_last;

  logic [IDX_W-1:0] head_idx;
  logic             exists;
  logic             active;
  logic [VW-1:0]    dec;
  logic             fire;
  logic             stall;

  assign out_free = !out_valid || results.ready;
  assign head_idx = q_item.slot[IDX_W-1:0];
  assign exists   = q_item.in_cap && slot_valid[head_idx];
  assign active   = slot_valid[proc_idx] && slot_running[proc_idx];
  assign dec      = (cnt_q != '0) ? cnt_q - VW'(1) : cnt_q;
  assign fire     = active && (dec == '0);
  // a second expiry needs the held one out of the way first
  assign stall    = fire && pend_valid && !out_free;

  always_comb begin
    state_next     = state;
    q_ready        = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = head_idx;
    wr_addr        = head_idx;
    cnt_we         = 1'b0;
    cnt_wdata      = q_item.reload_value;
    rel_we         = 1'b0;
    valid_next     = slot_valid;
    run_next       = slot_running;
    ar_next        = slot_ar;
    tiu_next       = timers_in_use;
    tick_next      = tick_counter;
    proc_next      = proc_idx;
    pend_next      = pend_valid;
    pend_slot_next = pend_slot;
    emit           = 1'b0;
    emit_status    = stb_pkg::ST_OK;
    emit_fired     = 1'b0;
    emit_slot      = '0;
    emit_last      = 1'b1;

    unique case (state)
      stb_pkg::E_IDLE: begin
        if (q_valid) begin
          rd_en = 1'b1;
          if (q_item.kind == stb_pkg::K_TICK) begin
            rd_addr    = '0;
            proc_next  = '0;
            tick_next  = tick_counter + VW'(1);
            state_next = stb_pkg::E_SWEEP;
          end else begin
            state_next = stb_pkg::E_CMD;
          end
        end
      end

      stb_pkg::E_CMD: begin
        if (out_free) begin
          emit       = 1'b1;
          q_ready    = 1'b1;
          state_next = stb_pkg::E_IDLE;
          unique case (q_item.kind)
            stb_pkg::K_CREATE: begin
              priority if (int'(timers_in_use) >= MAX_TIMERS || !q_item.in_cap) begin
                emit_status = stb_pkg::ST_NO_SPACE;
              end else if (slot_valid[head_idx]) begin
                emit_status = stb_pkg::ST_EXISTS;
              end else begin
                valid_next[head_idx] = 1'b1;
                ar_next[head_idx]    = q_item.auto_reload;
                run_next[head_idx]   = q_item.run_enable;
                rel_we               = 1'b1;
                cnt_we               = 1'b1;
                tiu_next             = timers_in_use + TIU_W'(1);
              end
            end
            stb_pkg::K_REMOVE: begin
              if (!exists) begin
                emit_status = stb_pkg::ST_NO_TIMER;
              end else begin
                // memory contents of a free slot are never used
                valid_next[head_idx] = 1'b0;
                ar_next[head_idx]    = 1'b0;
                run_next[head_idx]   = 1'b0;
                tiu_next             = timers_in_use - TIU_W'(1);
              end
            end
            stb_pkg::K_PAUSE: begin
              if (!exists) emit_status = stb_pkg::ST_NO_TIMER;
              else run_next[head_idx] = 1'b0;
            end
            stb_pkg::K_RESUME: begin
              if (!exists) emit_status = stb_pkg::ST_NO_TIMER;
              else run_next[head_idx] = 1'b1;
            end
            stb_pkg::K_RESET: begin
              if (!exists) begin
                emit_status = stb_pkg::ST_NO_TIMER;
              end else begin
                cnt_we             = 1'b1;
                cnt_wdata          = rel_q;
                run_next[head_idx] = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      stb_pkg::E_SWEEP: begin
        if (!stall) begin
          wr_addr = proc_idx;
          if (active) begin
            cnt_we    = 1'b1;
            cnt_wdata = fire ? rel_q : dec;
          end
          if (fire) begin
            if (pend_valid) begin
              emit       = 1'b1;
              emit_fired = 1'b1;
              emit_slot  = pend_slot;
              emit_last  = 1'b0;
            end
            pend_next      = 1'b1;
            pend_slot_next = SW'(proc_idx);
            if (!slot_ar[proc_idx]) run_next[proc_idx] = 1'b0;
          end
          if (proc_idx == LAST_IDX) begin
            state_next = stb_pkg::E_FLUSH;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = proc_idx + IDX_W'(1);
            proc_next = proc_idx + IDX_W'(1);
          end
        end
      end

      stb_pkg::E_FLUSH: begin
        if (out_free) begin
          // held expiry goes out as the final one, else an empty result
          emit       = 1'b1;
          emit_fired = pend_valid;
          emit_slot  = pend_valid ? pend_slot : '0;
          pend_next  = 1'b0;
          q_ready    = 1'b1;
          state_next = stb_pkg::E_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= stb_pkg::E_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid    <= '0;
      slot_running  <= '0;
      slot_ar       <= '0;
      timers_in_use <= '0;
      tick_counter  <= '0;
      proc_idx      <= '0;
      pend_valid    <= 1'b0;
    end else begin
      slot_valid    <= valid_next;
      slot_running  <= run_next;
      slot_ar       <= ar_next;
      timers_in_use <= tiu_next;
      tick_counter  <= tick_next;
      proc_idx      <= proc_next;
      pend_valid    <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_slot <= pend_slot_next;
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[wr_addr] <= cnt_wdata;
    if (rel_we) rel_mem[wr_addr] <= q_item.reload_value;
    if (rd_en) begin
      cnt_q <= cnt_mem[rd_addr];
      rel_q <= rel_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (emit) out_valid <= 1'b1;
    else if (results.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      results.status     <= emit_status;
      results.fired      <= emit_fired;
      results.fired_slot <= emit_slot;
      results.tick_count <= tick_next;
      results.last       <= emit_last;
    end
  end

  assign results.valid = out_valid;

  a_tiu_matches: assert property (@(posedge clk) disable iff (rst)
    int'(timers_in_use) == $countones(slot_valid))
    else $error("timer count disagrees with valid slots");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || results.ready))
    else $error("result written over one not yet taken");

  a_pop_state: assert property (@(posedge clk) disable iff (rst)
    q_ready |-> (state == stb_pkg::E_CMD || state == stb_pkg::E_FLUSH))
    else $error("queue popped outside command or flush");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (state == stb_pkg::E_IDLE) |-> !pend_valid)
    else $error("expiry held across ticks");

endmodule

FILE: tb/multi_channel_soft_timer_bank_test.sv
// Self-checking testbench for the soft timer bank: predicted results versus the result channel.
`timescale 1ns / 1ps

typedef struct packed {
  logic [stb_pkg::CMD_W-1:0]   cmd;
  logic [stb_pkg::SLOT_W-1:0]  slot;
  logic [stb_pkg::VALUE_W-1:0] reload_value;
  logic                        auto_reload;
  logic                        run_enable;
} timer_cmd_t;

typedef struct packed {
  stb_pkg::status_t            status;
  logic                        fired;
  logic [stb_pkg::SLOT_W-1:0]  fired_slot;
  logic [stb_pkg::VALUE_W-1:0] tick_count;
  logic                        last;
} timer_result_t;

class timer_bank_tracker;
  bit                        in_use   [stb_pkg::NUM_SLOTS];
  bit                        auto_q   [stb_pkg::NUM_SLOTS];
  bit                        run_q    [stb_pkg::NUM_SLOTS];
  bit [stb_pkg::VALUE_W-1:0] reload_q [stb_pkg::NUM_SLOTS];
  bit [stb_pkg::VALUE_W-1:0] count_q  [stb_pkg::NUM_SLOTS];
  int unsigned               active_timers;
  bit [stb_pkg::VALUE_W-1:0] ticks;
  int unsigned               capacity;
  timer_result_t             due_results[$];
  int unsigned               fault_count;

  function new(int unsigned max_timers);
    capacity = max_timers;
    active_timers = 0;
    ticks = '0;
    fault_count = 0;
    for (int i = 0; i < stb_pkg::NUM_SLOTS; i++) begin
      in_use[i] = 0;
      auto_q[i] = 0;
      run_q[i] = 0;
      reload_q[i] = '0;
      count_q[i] = '0;
    end
  endfunction

  function int unsigned outstanding();
    return due_results.size();
  endfunction

  // Predict the results of one accepted command and queue them.
  function void record_command(timer_cmd_t c);
    timer_result_t    r;
    stb_pkg::status_t st;
    bit               present;
    int unsigned      s;
    int unsigned      n_fired;
    s = int'(c.slot);
    present = (s < capacity) && in_use[s];
    st = stb_pkg::ST_OK;
    n_fired = 0;
    if (c.cmd == stb_pkg::CMD_TICK) begin
      ticks = ticks + 1;
      for (int i = 0; i < stb_pkg::NUM_SLOTS; i++) begin
        if (!in_use[i] || !run_q[i]) continue;
        if (count_q[i] != 0) count_q[i] = count_q[i] - 1;
        if (count_q[i] == 0) begin
          count_q[i] = reload_q[i];
          if (!auto_q[i]) run_q[i] = 0;
          r.status = stb_pkg::ST_OK;
          r.fired = 1'b1;
          r.fired_slot = i[stb_pkg::SLOT_W-1:0];
          r.tick_count = ticks;
          r.last = 1'b0;
          due_results.push_back(r);
          n_fired++;
        end
      end
      if (n_fired == 0) begin
        r.status = stb_pkg::ST_OK;
        r.fired = 1'b0;
        r.fired_slot = '0;
        r.tick_count = ticks;
        r.last = 1'b1;
        due_results.push_back(r);
      end else begin
        due_results[due_results.size()-1].last = 1'b1;
      end
      return;
    end
    case (c.cmd)
      stb_pkg::CMD_CREATE: begin
        // capacity check wins over the slot-in-use check
        if (active_timers >= capacity || s >= capacity) st = stb_pkg::ST_NO_SPACE;
        else if (in_use[s]) st = stb_pkg::ST_EXISTS;
        else begin
          in_use[s] = 1;
          auto_q[s] = c.auto_reload;
          run_q[s] = c.run_enable;
          reload_q[s] = c.reload_value;
          count_q[s] = c.reload_value;
          active_timers++;
        end
      end
      stb_pkg::CMD_REMOVE: begin
        if (!present) st = stb_pkg::ST_NO_TIMER;
        else begin
          in_use[s] = 0;
          auto_q[s] = 0;
          run_q[s] = 0;
          reload_q[s] = '0;
          count_q[s] = '0;
          active_timers--;
        end
      end
      stb_pkg::CMD_PAUSE: begin
        if (!present) st = stb_pkg::ST_NO_TIMER;
        else run_q[s] = 0;
      end
      stb_pkg::CMD_RESUME: begin
        if (!present) st = stb_pkg::ST_NO_TIMER;
        else run_q[s] = 1;
      end
      stb_pkg::CMD_RESET: begin
        if (!present) st = stb_pkg::ST_NO_TIMER;
        else begin
          count_q[s] = reload_q[s];
          run_q[s] = 1;
        end
      end
      default: ;
    endcase
    r.status = st;
    r.fired = 1'b0;
    r.fired_slot = '0;
    r.tick_count = ticks;
    r.last = 1'b1;
    due_results.push_back(r);
  endfunction

  // Compare one transferred result with the oldest prediction.
  function void match_result(timer_result_t got);
    timer_result_t want;
    if (due_results.size() == 0) begin
      fault_count++;
      if (fault_count <= 10)
        $display("unexpected result: status %0d fired %0b slot %0d ticks %0d last %0b",
                 got.status, got.fired, got.fired_slot, got.tick_count, got.last);
      return;
    end
    want = due_results.pop_front();
    if (got.status !== want.status || got.fired !== want.fired ||
        got.fired_slot !== want.fired_slot || got.tick_count !== want.tick_count ||
        got.last !== want.last) begin
      fault_count++;
      if (fault_count <= 10)
        $display("mismatch: expected status %0d fired %0b slot %0d ticks %0d last %0b, %s",
                 want.status, want.fired, want.fired_slot, want.tick_count, want.last,
                 $sformatf("got status %0d fired %0b slot %0d ticks %0d last %0b",
                           got.status, got.fired, got.fired_slot, got.tick_count,
                           got.last));
    end
  endfunction
endclass

module multi_channel_soft_timer_bank_test;

  localparam logic [stb_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [stb_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_PER_PHASE = 130;

  logic clk;
  logic rst;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  timer_bank_tracker tracker;

  stb_in_if  cmd_ch ();
  stb_out_if res_ch ();

  multi_channel_soft_timer_bank dut (
    .clk     (clk),
    .rst     (rst),
    .items   (cmd_ch),
    .results (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Present one command and hold it until the transfer.
  task automatic send_cmd(input logic [stb_pkg::CMD_W-1:0] cmd,
                          input logic [stb_pkg::SLOT_W-1:0] slot,
                          input logic [stb_pkg::VALUE_W-1:0] value, input logic auto_rl,
                          input logic run_en);
    timer_cmd_t c;
    c.cmd = cmd;
    c.slot = slot;
    c.reload_value = value;
    c.auto_reload = auto_rl;
    c.run_enable = run_en;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.cmd          <= c.cmd;
    cmd_ch.slot         <= c.slot;
    cmd_ch.reload_value <= c.reload_value;
    cmd_ch.auto_reload  <= c.auto_reload;
    cmd_ch.run_enable   <= c.run_enable;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    tracker.record_command(c);
  endtask

  // Hold the command channel until every predicted result has come back.
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [stb_pkg::VALUE_W-1:0] pick_reload();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 7) return $urandom_range(6);
    if (sel < 9) return $urandom_range(40);
    return $urandom();
  endfunction

  task automatic send_random_cmd();
    int unsigned sel;
    logic [stb_pkg::CMD_W-1:0] cmd;
    sel = $urandom_range(99);
    if (sel < 45) cmd = stb_pkg::CMD_TICK;
    else if (sel < 67) cmd = stb_pkg::CMD_CREATE;
    else if (sel < 77) cmd = stb_pkg::CMD_REMOVE;
    else if (sel < 84) cmd = stb_pkg::CMD_PAUSE;
    else if (sel < 91) cmd = stb_pkg::CMD_RESUME;
    else if (sel < 98) cmd = stb_pkg::CMD_RESET;
    else cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
    send_cmd(cmd, 4'($urandom_range(15)), pick_reload(), 1'($urandom_range(1)),
             1'($urandom_range(1)));
  endtask

  // Fill every slot, overflow once, then tick with a crowded bank.
  task automatic fill_bank();
    for (int s = 0; s < stb_pkg::NUM_SLOTS; s++)
      send_cmd(stb_pkg::CMD_CREATE, s[stb_pkg::SLOT_W-1:0], $urandom_range(3),
               1'($urandom_range(1)), $urandom_range(3) != 0);
    send_cmd(stb_pkg::CMD_CREATE, 4'($urandom_range(15)), pick_reload(), 1'b1, 1'b1);
    repeat (4) send_cmd(stb_pkg::CMD_TICK, 4'($urandom_range(15)), $urandom(),
                        1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready)
        tracker.match_result({stb_pkg::status_t'(res_ch.status), res_ch.fired,
                              res_ch.fired_slot, res_ch.tick_count, res_ch.last});
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Stop the run when neither channel moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    tracker = new(stb_pkg::MAX_TIMERS_DEF);
    send_idle_pct = 9;
    recv_idle_pct = 71;
    rst <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.cmd <= stb_pkg::CMD_TICK;
    cmd_ch.slot <= '0;
    cmd_ch.reload_value <= '0;
    cmd_ch.auto_reload <= 1'b0;
    cmd_ch.run_enable <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty bank, unused codes, a duplicate create, zero reload, reload on expiry
    send_cmd(stb_pkg::CMD_TICK, 0, 0, 0, 0);
    send_cmd(stb_pkg::CMD_PAUSE, 3, 0, 0, 0);
    send_cmd(stb_pkg::CMD_REMOVE, 15, 0, 0, 0);
    send_cmd(stb_pkg::CMD_RESUME, 0, 0, 0, 0);
    send_cmd(stb_pkg::CMD_RESET, 7, 0, 0, 0);
    send_cmd(CMD_SPARE_LO, 9, 32'hFFFF_FFFF, 1, 1);
    send_cmd(CMD_SPARE_HI, 6, 32'h5A5A_A5A5, 0, 1);
    send_cmd(stb_pkg::CMD_CREATE, 0, 0, 1, 1);
    send_cmd(stb_pkg::CMD_CREATE, 0, 5, 0, 0);
    send_cmd(stb_pkg::CMD_CREATE, 15, 32'hFFFF_FFFF, 0, 0);
    send_cmd(stb_pkg::CMD_CREATE, 5, 2, 0, 1);
    send_cmd(stb_pkg::CMD_CREATE, 9, 1, 1, 1);
    repeat (3) send_cmd(stb_pkg::CMD_TICK, 0, 0, 0, 0);
    send_cmd(stb_pkg::CMD_RESET, 5, 0, 0, 0);
    send_cmd(stb_pkg::CMD_RESUME, 15, 0, 0, 0);
    send_cmd(stb_pkg::CMD_PAUSE, 0, 0, 0, 0);
    repeat (2) send_cmd(stb_pkg::CMD_TICK, 0, 0, 0, 0);
    send_cmd(stb_pkg::CMD_REMOVE, 0, 0, 0, 0);
    send_cmd(stb_pkg::CMD_REMOVE, 0, 0, 0, 0);
    send_cmd(stb_pkg::CMD_TICK, 0, 0, 0, 0);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 9;  recv_idle_pct = 71; end
        1: begin send_idle_pct = 71; recv_idle_pct = 9;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      fill_bank();
      repeat (RANDOM_PER_PHASE / 2) send_random_cmd();
      drain_results();
      repeat (RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2) send_random_cmd();
    end
    cmd_ch.valid <= 1'b0;

    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.fault_count == 0 && tracker.outstanding() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule

FILE: files.f
sv/stb_pkg.sv
sv/stb_in_if.sv
sv/stb_out_if.sv
sv/stb_front.sv
sv/stb_engine.sv
sv/multi_channel_soft_timer_bank.sv
tb/multi_channel_soft_timer_bank_test.sv
